FILE: src/line_near_clip_octa_encode_macros.svh
// Assertion macros for the line clip and octahedral encode block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef LINE_NEAR_CLIP_OCTA_ENCODE_MACROS_SVH
`define LINE_NEAR_CLIP_OCTA_ENCODE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LNCO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LNCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lnco_pkg.sv
// Shared widths, constants and request/status types for the line clip block.
// No dependencies.
package lnco_pkg;

  localparam int COORD_W = 32;
  localparam int MPL_W   = 32;
  localparam int MCNT_W  = $clog2(MPL_W);
  localparam int ACC_W   = 66;
  localparam int DIFF_W  = 33;
  localparam int DEPTH_W = 52;
  localparam int NUM_W   = DEPTH_W + 1;
  localparam int DIV_W   = 54;
  localparam int Q_W     = 31;
  localparam int FRAC_W  = 5;
  localparam int OCTA_W  = 16;
  localparam int MAG_W   = 15;
  localparam int L1_W    = 35;
  localparam int VC_W    = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [DEPTH_W-1:0] NEAR_Q16 = DEPTH_W'(-3277);
  localparam logic [FRAC_W-1:0] T_FRAC    = 5'd30;
  localparam logic [FRAC_W-1:0] OCTA_FRAC = 5'd14;
  localparam logic [OCTA_W-1:0] OCTA_ONE  = 16'd16384;
  localparam logic signed [ACC_W-1:0] ROUND_Q30 = ACC_W'(64'd536870912);
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ZX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZZ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS = 2'd3;

  typedef struct packed {
    logic                     start;
    logic                     clear;
    logic signed [DIFF_W-1:0] mcand;
    logic [MPL_W-1:0]         mplier;
  } mac_req_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] frac;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: src/lnco_if.sv
// Handshake channels of the line clip block: one line in, one kept line out.
// No dependencies.
interface lnco_in_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [31:0]        argb_color;
  logic [15:0]        line_width;
  logic               on_top;
  logic               depth_bias;

  modport source(output valid, frame_start, start_x, start_y, start_z, end_x, end_y, end_z,
                 argb_color, line_width, on_top, depth_bias, input ready);
  modport sink(input valid, frame_start, start_x, start_y, start_z, end_x, end_y, end_z,
               argb_color, line_width, on_top, depth_bias, output ready);
endinterface

interface lnco_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_start_x;
  logic signed [31:0] out_start_y;
  logic signed [31:0] out_start_z;
  logic signed [31:0] out_end_x;
  logic signed [31:0] out_end_y;
  logic signed [31:0] out_end_z;
  logic signed [15:0] octa_u;
  logic signed [15:0] octa_v;
  logic [31:0]        out_color;
  logic [17:0]        base_vertex;
  logic               new_group;

  modport source(output valid, out_start_x, out_start_y, out_start_z, out_end_x, out_end_y,
                 out_end_z, octa_u, octa_v, out_color, base_vertex, new_group, input ready);
  modport sink(input valid, out_start_x, out_start_y, out_start_z, out_end_x, out_end_y,
               out_end_z, octa_u, octa_v, out_color, base_vertex, new_group, output ready);
endinterface

FILE: src/lnco_mac.sv
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on lnco_pkg.
module lnco_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lnco_pkg::mac_req_t                  req,
  output lnco_pkg::unit_stat_t                stat,
  output logic signed [lnco_pkg::ACC_W-1:0]   acc
);
  import lnco_pkg::*;

  logic                    busy_r, done_r;
  logic [MCNT_W-1:0]       cnt_r;
  logic signed [ACC_W-1:0] mc_r, acc_r;
  logic [MPL_W-1:0]        mp_r;
  logic signed [ACC_W-1:0] addend, sum;
  logic                    last;

  always_comb begin
    last   = (cnt_r == MCNT_W'(MPL_W - 1));
    addend = mp_r[0] ? mc_r : '0;
    // The top multiplier bit carries negative weight.
    sum    = last ? (acc_r - addend) : (acc_r + addend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mc_r <= ACC_W'(req.mcand);
      mp_r <= req.mplier;
      if (req.clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r <= sum;
      mc_r  <= mc_r <<< 1;
      mp_r  <= mp_r >> 1;
    end
  end

  assign acc       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

FILE: src/lnco_div.sv
// Restoring fraction divider: num/den rounded half up to a given number of
// fraction bits, one quotient bit per cycle, result clamped to 1.0. Uses lnco_pkg.
module lnco_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lnco_pkg::div_req_t           req,
  output lnco_pkg::unit_stat_t         stat,
  output logic [lnco_pkg::Q_W-1:0]     quot
);
  import lnco_pkg::*;

  logic              busy_r, done_r;
  logic [FRAC_W-1:0] cnt_r;
  logic [DIV_W-1:0]  r_r, d_r, r2;
  logic [Q_W-1:0]    q_r;

  assign r2 = r_r << 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.frac;
        if (req.num >= req.den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r <= req.num;
      d_r <= req.den;
      q_r <= (req.num >= req.den) ? (Q_W'(1) << req.frac) : '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (r2 >= d_r) begin
          r_r <= r2 - d_r;
          q_r <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          r_r <= r2;
          q_r <= {q_r[Q_W-2:0], 1'b0};
        end
      end else if (r2 >= d_r) begin
        // Round half up on the final remainder.
        q_r <= q_r + 1'b1;
      end
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

FILE: src/line_near_clip_octa_encode.sv
// Near-plane line clip with octahedral direction code; top level and sequencer.
// Depends on lnco_pkg, lnco_if, lnco_mac, lnco_div and the assertion macro header.
// One line at a time: six serial depth products, then for a cut line a division (skipped
// when the cut ratio is zero) and three interpolation products, then two divisions for
// the octahedral code; a new line is taken only once the last one is committed or
// dropped, and the serial MAC sets the pace.
// Synchronous active-low reset clears control, counters and group memory, and resets config.
`include "line_near_clip_octa_encode_macros.svh"
module line_near_clip_octa_encode #(
  parameter int MAX_LINES = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lnco_in_if.sink                           in_ch,
  lnco_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lnco_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata
);
  import lnco_pkg::*;

  localparam int CAP = (MAX_LINES < 65536) ? MAX_LINES : 65536;
  localparam logic [VC_W-2:0] CAP_V = (VC_W-1)'(CAP);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEPTH  = 4'd1;
  localparam logic [3:0] S_SEL    = 4'd2;
  localparam logic [3:0] S_CLIP   = 4'd3;
  localparam logic [3:0] S_LERP   = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_OCTU   = 4'd6;
  localparam logic [3:0] S_OCTV   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0]                state_r;
  logic [2:0]                step_r;
  logic                      go_r;
  logic                      go_nxt;
  logic signed [31:0]        zx_r, zy_r, zz_r, zo_r;
  logic signed [31:0]        pa_r [3];
  logic signed [31:0]        pb_r [3];
  logic [31:0]               color_r;
  logic [15:0]               width_r;
  logic                      top_r, bias_r, a_beh_r;
  logic signed [DEPTH_W-1:0] za_r, zb_r;
  logic [Q_W-1:0]            t_r;
  logic [MAG_W-1:0]          mu_r, mv_r;
  logic [VC_W-1:0]           vc_r;
  logic                      limit_r, gvalid_r, gtop_r, gtrans_r, gbias_r;
  logic [15:0]               gwidth_r;

  logic                      out_valid_r, out_group_r;
  logic signed [31:0]        out_sx_r, out_sy_r, out_sz_r, out_ex_r, out_ey_r, out_ez_r;
  logic signed [15:0]        out_u_r, out_v_r;
  logic [31:0]               out_color_r;
  logic [VC_W-1:0]           out_base_r;

  mac_req_t                  mac_req;
  div_req_t                  div_req;
  unit_stat_t                mac_stat, div_stat;
  logic signed [ACC_W-1:0]   acc;
  logic [Q_W-1:0]            quot;

  logic                      in_acc, commit_w;
  logic [1:0]                ax;
  logic signed [31:0]        pa_cur, pb_cur, coef_cur, coord_cur;
  logic signed [DIFF_W-1:0]  dcur;
  logic signed [DIFF_W-1:0]  dw [3];
  logic [DIFF_W-1:0]         dabs [3];
  logic [L1_W-1:0]           l1;
  logic                      dzero;
  logic signed [DEPTH_W-1:0] depth_w;
  logic signed [NUM_W-1:0]   num_w, den_w;
  logic [NUM_W-1:0]          num_mag, den_mag;
  logic                      a_beh_w, b_beh_w, t_zero;
  logic signed [ACC_W-1:0]   lerp_sum;
  logic [31:0]               cut_w;
  logic [OCTA_W-1:0]         fu, fv;
  logic signed [OCTA_W-1:0]  u_w, v_w;
  logic                      trans_w, newgrp_w;
  logic [VC_W:0]             next_vc;

  lnco_mac u_mac (.clk, .rst_n, .req(mac_req), .stat(mac_stat), .acc);
  lnco_div u_div (.clk, .rst_n, .req(div_req), .stat(div_stat), .quot);

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign commit_w     = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ax       = '0;
    if (state_r == S_DEPTH) begin
      ax = (step_r < 3'd3) ? step_r[1:0] : 2'(step_r - 3'd3);
    end else begin
      ax = step_r[1:0];
    end
    pa_cur    = pa_r[ax];
    pb_cur    = pb_r[ax];
    coord_cur = (step_r < 3'd3) ? pa_cur : pb_cur;
    case (ax)
      2'd0:    coef_cur = zx_r;
      2'd1:    coef_cur = zy_r;
      default: coef_cur = zz_r;
    endcase
    dcur = DIFF_W'(pb_cur) - DIFF_W'(pa_cur);

    for (int i = 0; i < 3; i++) begin
      dw[i]   = DIFF_W'(pb_r[i]) - DIFF_W'(pa_r[i]);
      dabs[i] = dw[i][DIFF_W-1] ? DIFF_W'(-dw[i]) : DIFF_W'(dw[i]);
    end
    l1    = L1_W'(dabs[0]) + L1_W'(dabs[1]) + L1_W'(dabs[2]);
    dzero = (dw[0] == '0) && (dw[1] == '0) && (dw[2] == '0);

    // Floor of the exact product sum to Q16.16, then the translation term.
    depth_w = DEPTH_W'(acc >>> 16) + DEPTH_W'(zo_r);

    num_w   = NUM_W'(NEAR_Q16) - NUM_W'(za_r);
    den_w   = NUM_W'(zb_r) - NUM_W'(za_r);
    num_mag = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
    den_mag = den_w[NUM_W-1] ? NUM_W'(-den_w) : NUM_W'(den_w);
    a_beh_w = za_r > NEAR_Q16;
    b_beh_w = zb_r > NEAR_Q16;
    t_zero  = (num_w[NUM_W-1] != den_w[NUM_W-1]) || (num_w == '0);

    lerp_sum = acc + ROUND_Q30;
    cut_w    = pa_cur + lerp_sum[30 +: 32];

    mac_req.start  = go_r && ((state_r == S_DEPTH) || (state_r == S_LERP));
    mac_req.clear  = (state_r == S_LERP) || (step_r == 3'd0) || (step_r == 3'd3);
    mac_req.mcand  = (state_r == S_LERP) ? dcur : DIFF_W'(coef_cur);
    mac_req.mplier = (state_r == S_LERP) ? MPL_W'(t_r) : coord_cur;

    div_req.start = go_r && ((state_r == S_CLIP) || (state_r == S_OCTU) ||
                             (state_r == S_OCTV));
    if (state_r == S_CLIP) begin
      div_req.frac = T_FRAC;
      div_req.num  = DIV_W'(num_mag);
      div_req.den  = DIV_W'(den_mag);
    end else begin
      div_req.frac = OCTA_FRAC;
      div_req.num  = (state_r == S_OCTU) ? DIV_W'(dabs[0]) : DIV_W'(dabs[1]);
      div_req.den  = DIV_W'(l1);
    end

    // Lower hemisphere folds over the diagonals.
    if (dw[2][DIFF_W-1]) begin
      fu = OCTA_ONE - OCTA_W'(mv_r);
      fv = OCTA_ONE - OCTA_W'(mu_r);
    end else begin
      fu = OCTA_W'(mu_r);
      fv = OCTA_W'(mv_r);
    end
    u_w = dw[0][DIFF_W-1] ? OCTA_W'(-fu) : OCTA_W'(fu);
    v_w = dw[1][DIFF_W-1] ? OCTA_W'(-fv) : OCTA_W'(fv);

    trans_w  = color_r[31:24] != ALPHA_OPAQUE;
    newgrp_w = !gvalid_r || (gwidth_r != width_r) || (gtop_r != top_r) ||
               (gtrans_r != trans_w) || (gbias_r != bias_r);
    next_vc  = (VC_W+1)'(vc_r) + (VC_W+1)'(4);
  end

  // A unit is started the cycle after the sequencer asks for it.
  always_comb begin
    unique case (state_r)
      S_IDLE:  go_nxt = in_acc && (in_ch.frame_start || !limit_r);
      S_DEPTH: go_nxt = mac_stat.done && (step_r != 3'd5);
      S_SEL:   go_nxt = (a_beh_w != b_beh_w) && (den_w != '0);
      S_CLIP:  go_nxt = div_stat.done;
      S_LERP:  go_nxt = mac_stat.done && (step_r != 3'd2);
      S_CHECK: go_nxt = !dzero;
      S_OCTU:  go_nxt = div_stat.done;
      default: go_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      go_r        <= 1'b0;
      zx_r        <= '0;
      zy_r        <= '0;
      zz_r        <= 32'sd65536;
      zo_r        <= '0;
      vc_r        <= '0;
      limit_r     <= 1'b0;
      gvalid_r    <= 1'b0;
      gwidth_r    <= '0;
      gtop_r      <= 1'b0;
      gtrans_r    <= 1'b0;
      gbias_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= go_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZX:  zx_r <= cfg_wdata;
          CFG_ZY:  zy_r <= cfg_wdata;
          CFG_ZZ:  zz_r <= cfg_wdata;
          CFG_OFS: zo_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit_w) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.frame_start) begin
              vc_r     <= '0;
              gvalid_r <= 1'b0;
              limit_r  <= 1'b0;
            end
            if (in_ch.frame_start || !limit_r) begin
              state_r <= S_DEPTH;
              step_r  <= '0;
            end
          end
        end
        S_DEPTH: begin
          if (mac_stat.done) begin
            if (step_r == 3'd2) begin
              za_r <= depth_w;
            end
            if (step_r == 3'd5) begin
              zb_r    <= depth_w;
              state_r <= S_SEL;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_SEL: begin
          a_beh_r <= a_beh_w;
          if (a_beh_w && b_beh_w) begin
            state_r <= S_IDLE;
          end else if (!a_beh_w && !b_beh_w) begin
            state_r <= S_CHECK;
          end else if (den_w == '0) begin
            state_r <= S_IDLE;
          end else if (t_zero) begin
            t_r     <= '0;
            step_r  <= '0;
            state_r <= S_LERP;
          end else begin
            state_r <= S_CLIP;
          end
        end
        S_CLIP: begin
          if (div_stat.done) begin
            t_r     <= quot;
            step_r  <= '0;
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          if (mac_stat.done) begin
            if (step_r == 3'd2) begin
              state_r <= S_CHECK;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (dzero) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_OCTU;
          end
        end
        S_OCTU: begin
          if (div_stat.done) begin
            mu_r    <= quot[MAG_W-1:0];
            state_r <= S_OCTV;
          end
        end
        S_OCTV: begin
          if (div_stat.done) begin
            mv_r    <= quot[MAG_W-1:0];
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_w) begin
            if (newgrp_w) begin
              gvalid_r <= 1'b1;
              gwidth_r <= width_r;
              gtop_r   <= top_r;
              gtrans_r <= trans_w;
              gbias_r  <= bias_r;
            end
            if (next_vc[VC_W:2] >= CAP_V) begin
              limit_r <= 1'b1;
            end
            vc_r    <= next_vc[VC_W-1:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pa_r[0] <= in_ch.start_x;
      pa_r[1] <= in_ch.start_y;
      pa_r[2] <= in_ch.start_z;
      pb_r[0] <= in_ch.end_x;
      pb_r[1] <= in_ch.end_y;
      pb_r[2] <= in_ch.end_z;
      color_r <= in_ch.argb_color;
      width_r <= in_ch.line_width;
      top_r   <= in_ch.on_top;
      bias_r  <= in_ch.depth_bias;
    end else if ((state_r == S_LERP) && mac_stat.done) begin
      // The end behind the near plane is replaced, one axis per product.
      if (a_beh_r) begin
        pa_r[ax] <= cut_w;
      end else begin
        pb_r[ax] <= cut_w;
      end
    end
    if (commit_w) begin
      out_sx_r    <= pa_r[0];
      out_sy_r    <= pa_r[1];
      out_sz_r    <= pa_r[2];
      out_ex_r    <= pb_r[0];
      out_ey_r    <= pb_r[1];
      out_ez_r    <= pb_r[2];
      out_u_r     <= u_w;
      out_v_r     <= v_w;
      out_color_r <= color_r;
      out_base_r  <= vc_r;
      out_group_r <= newgrp_w;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_start_x = out_sx_r;
  assign out_ch.out_start_y = out_sy_r;
  assign out_ch.out_start_z = out_sz_r;
  assign out_ch.out_end_x   = out_ex_r;
  assign out_ch.out_end_y   = out_ey_r;
  assign out_ch.out_end_z   = out_ez_r;
  assign out_ch.octa_u      = out_u_r;
  assign out_ch.octa_v      = out_v_r;
  assign out_ch.out_color   = out_color_r;
  assign out_ch.base_vertex = out_base_r;
  assign out_ch.new_group   = out_group_r;

  `LNCO_ASSERT_NOW(a_units_excl, 1'b1, !(mac_stat.busy && div_stat.busy), "mac and divider both busy")
  `LNCO_ASSERT_NOW(a_base_aligned, out_valid_r, out_base_r[1:0] == 2'b00, "base vertex not aligned")
  `LNCO_ASSERT_NEXT(a_no_fast_commit, in_acc, !commit_w, "commit right after accept")
endmodule

FILE: tb/tb_line_near_clip_octa_encode.sv
// Testbench for the near-plane line clip and octahedral encode block.
// Self-checking: an in-bench model predicts each kept line and compares it field by field.
// Depends on lnco_pkg, lnco_if and the line_near_clip_octa_encode RTL.
module tb_line_near_clip_octa_encode;
  timeunit 1ns;
  timeprecision 1ps;
  import lnco_pkg::*;

  localparam int  ACCEPT_LIMIT = 20000;
  localparam int  HOLD_CYCLES  = 3000;
  localparam int  DRAIN_CYCLES = 500;
  localparam int  LINE_CAP     = 65536;
  localparam longint NEAR_PLANE = -3277;
  localparam longint VC_MASK    = 64'h3FFFF;

  typedef struct {
    bit               frame_start;
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [31:0]      color;
    logic [15:0]      width;
    bit               on_top;
    bit               bias;
  } line_t;

  typedef struct {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [15:0] u, v;
    logic [31:0] color;
    logic [17:0] base;
    bit          grp;
  } kept_line_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  lnco_in_if  in_ch();
  lnco_out_if out_ch();

  line_near_clip_octa_encode dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Model state and view row.
  logic signed [31:0] row_zx = 0, row_zy = 0, row_zz = 32'sd65536, row_ofs = 0;
  longint vertex_count = 0;
  bit grp_valid = 0, grp_on_top = 0, grp_transl = 0, grp_bias = 0, limit_hit = 0;
  logic [15:0] grp_width = 0;

  kept_line_t expected_lines[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint eye_depth(logic signed [31:0] x, y, z);
    logic signed [67:0] s;
    s = row_zx * x + row_zy * y + row_zz * z;
    return longint'((s >>> 16) + row_ofs);
  endfunction

  function automatic longint cut_ratio(longint unsigned n, longint unsigned d);
    longint unsigned r, q;
    r = n;
    q = 0;
    if (n >= d) return 64'd1 << 30;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (2 * r >= d) q++;
    return (q > (64'd1 << 30)) ? (64'd1 << 30) : q;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint t);
    logic signed [99:0] p;
    p = (100'(signed'(b)) - 100'(signed'(a))) * 100'(signed'(t));
    return a + longint'((p + (100'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Predicts the kept line, if any, and updates the vertex counter and group memory.
  function automatic void clip_and_encode(line_t l);
    longint a[3], b[3], d[3], za, zb, num, den, t, u, v;
    longint unsigned l1, mu, mv, nu, nv;
    bit a_behind, b_behind, transl;
    kept_line_t k;
    if (l.frame_start) begin
      vertex_count = 0;
      grp_valid = 0;
      limit_hit = 0;
    end
    if (limit_hit) return;
    a = '{l.sx, l.sy, l.sz};
    b = '{l.ex, l.ey, l.ez};
    za = eye_depth(l.sx, l.sy, l.sz);
    zb = eye_depth(l.ex, l.ey, l.ez);
    a_behind = za > NEAR_PLANE;
    b_behind = zb > NEAR_PLANE;
    if (a_behind && b_behind) return;
    if (a_behind || b_behind) begin
      num = NEAR_PLANE - za;
      den = zb - za;
      if (den == 0) return;
      if (((num < 0) != (den < 0)) || num == 0) t = 0;
      else t = cut_ratio(mag(num), mag(den));
      for (int i = 0; i < 3; i++) begin
        if (a_behind) a[i] = lerp_q16(a[i], b[i], t);
        else b[i] = lerp_q16(a[i], b[i], t);
      end
    end
    for (int i = 0; i < 3; i++) d[i] = b[i] - a[i];
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) return;
    transl = l.color[31:24] < 8'hFF;
    k.grp = 0;
    if (!grp_valid || grp_width != l.width || grp_on_top != l.on_top ||
        grp_transl != transl || grp_bias != l.bias) begin
      grp_valid = 1;
      grp_width = l.width;
      grp_on_top = l.on_top;
      grp_transl = transl;
      grp_bias = l.bias;
      k.grp = 1;
    end
    l1 = mag(d[0]) + mag(d[1]) + mag(d[2]);
    mu = (mag(d[0]) * 2 * 16384 + l1) / (2 * l1);
    mv = (mag(d[1]) * 2 * 16384 + l1) / (2 * l1);
    if (d[2] < 0) begin
      nu = 16384 - (mv > 16384 ? 16384 : mv);
      nv = 16384 - (mu > 16384 ? 16384 : mu);
      mu = nu;
      mv = nv;
    end
    u = d[0] >= 0 ? longint'(mu) : -longint'(mu);
    v = d[1] >= 0 ? longint'(mv) : -longint'(mv);
    k.sx = a[0][31:0]; k.sy = a[1][31:0]; k.sz = a[2][31:0];
    k.ex = b[0][31:0]; k.ey = b[1][31:0]; k.ez = b[2][31:0];
    k.u = u[15:0];
    k.v = v[15:0];
    k.color = l.color;
    k.base = vertex_count[17:0];
    expected_lines = {expected_lines, k};
    if (((vertex_count + 4) >> 2) >= LINE_CAP) limit_hit = 1;
    vertex_count = (vertex_count + 4) & VC_MASK;
  endfunction

  task automatic send_line(line_t l);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.frame_start = l.frame_start;
    in_ch.start_x = l.sx; in_ch.start_y = l.sy; in_ch.start_z = l.sz;
    in_ch.end_x = l.ex; in_ch.end_y = l.ey; in_ch.end_z = l.ez;
    in_ch.argb_color = l.color;
    in_ch.line_width = l.width;
    in_ch.on_top = l.on_top;
    in_ch.depth_bias = l.bias;
    in_ch.valid = 1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    clip_and_encode(l);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_ZX:  row_zx = val;
      CFG_ZY:  row_zy = val;
      CFG_ZZ:  row_zz = val;
      default: row_ofs = val;
    endcase
  endtask

  // Lets the block drain before the view row changes; a dropped line may still be in work.
  task automatic set_view(logic signed [31:0] zx, zy, zz, ofs);
    wait (expected_lines.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_row(CFG_ZX, zx);
    write_row(CFG_ZY, zy);
    write_row(CFG_ZZ, zz);
    write_row(CFG_OFS, ofs);
  endtask

  function automatic logic signed [31:0] rand_coord(bit front);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    if (front) return -$signed({12'd0, 20'($urandom)}) - 32'sd3277;
    return $signed({{12{1'b0}}, 20'($urandom)}) - 32'sd524288;
  endfunction

  function automatic line_t rand_line();
    line_t l;
    l.frame_start = ($urandom_range(49) == 0);
    l.sx = rand_coord(0); l.sy = rand_coord(0);
    l.ex = rand_coord(0); l.ey = rand_coord(0);
    l.sz = rand_coord($urandom_range(3) != 0);
    l.ez = rand_coord($urandom_range(2) != 0);
    if ($urandom_range(19) == 0) begin
      l.ex = l.sx; l.ey = l.sy; l.ez = l.sz;
    end
    l.color = $urandom;
    if ($urandom_range(1)) l.color[31:24] = 8'hFF;
    l.width = $urandom_range(3) == 0 ? 16'($urandom) : 16'h0100;
    l.on_top = $urandom_range(3) == 0;
    l.bias = $urandom_range(3) == 0;
    return l;
  endfunction

  function automatic line_t mk(logic signed [31:0] sx, sy, sz, ex, ey, ez);
    line_t l;
    l = '{frame_start: 0, sx: sx, sy: sy, sz: sz, ex: ex, ey: ey, ez: ez,
          color: 32'hFF336699, width: 16'h0100, on_top: 0, bias: 0};
    return l;
  endfunction

  task automatic test_directed();
    line_t l;
    send_line(mk(0, 0, -32'sh10000, 32'sh10000, 0, -32'sh20000));
    send_line(mk(0, 0, -32'sh10000, 0, 32'sh10000, 32'sh0));
    send_line(mk(0, 0, -32'sh10000, -32'sh30000, -32'sh10000, -32'sh8000));
    send_line(mk(0, 0, 32'sh10000, 32'sh1000, 32'sh2000, 32'sh20000));     // both behind
    send_line(mk(32'sh10000, 0, 32'sh10000, 0, 32'sh10000, -32'sh40000));  // start behind
    send_line(mk(0, 32'sh10000, -32'sh40000, 32'sh10000, 0, 32'sh10000));  // end behind
    send_line(mk(5, 6, -32'sh10000, 5, 6, -32'sh10000));                    // zero length
    send_line(mk(0, 0, -32'sd3277, 0, 0, 32'sh10000));                      // cut leaves a point
    send_line(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_line(mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    send_line(mk(0, 0, -32'sh10000, 0, 0, -32'sh10001));
    l = mk(0, 0, -32'sh10000, 1, -1, -32'sh10000);
    l.width = 16'hFFFF; l.on_top = 1; l.bias = 1; l.color = 32'h00FFFFFF;
    send_line(l);
    l.width = 16'h0000; l.color = 32'hFE000000;
    send_line(l);
    l.frame_start = 1; l.width = 16'h0000;
    send_line(l);
    l.frame_start = 0; l.bias = 0;
    send_line(l);
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_line(rand_line());
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 0;
      end
      repeat (40) send_line(rand_line());
    join
  endtask

  // Receiver: ready changes on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    kept_line_t k;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: kept line with none expected, actual base %h", $time,
                 out_ch.base_vertex);
      end else begin
        k = expected_lines.pop_front();
        check_field("out_start_x", k.sx, unsigned'(out_ch.out_start_x));
        check_field("out_start_y", k.sy, unsigned'(out_ch.out_start_y));
        check_field("out_start_z", k.sz, unsigned'(out_ch.out_start_z));
        check_field("out_end_x", k.ex, unsigned'(out_ch.out_end_x));
        check_field("out_end_y", k.ey, unsigned'(out_ch.out_end_y));
        check_field("out_end_z", k.ez, unsigned'(out_ch.out_end_z));
        check_field("octa_u", k.u, unsigned'(out_ch.octa_u));
        check_field("octa_v", k.v, unsigned'(out_ch.octa_v));
        check_field("out_color", k.color, out_ch.out_color);
        check_field("base_vertex", k.base, out_ch.base_vertex);
        check_field("new_group", k.grp, out_ch.new_group);
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= ACCEPT_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_ZX;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.frame_start = 0;
    in_ch.start_x = 0; in_ch.start_y = 0; in_ch.start_z = 0;
    in_ch.end_x = 0; in_ch.end_y = 0; in_ch.end_z = 0;
    in_ch.argb_color = 0;
    in_ch.line_width = 0;
    in_ch.on_top = 0;
    in_ch.depth_bias = 0;
    out_ch.ready = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    test_directed();
    test_random(400, 0, 0);
    test_random(300, 50, 0);
    test_backpressure();
    set_view(32'sh00010000, -32'sh00008000, 32'sh00020000, -32'sh00030000);
    test_directed();
    test_random(300, 0, 50);
    set_view(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    test_random(150, 12, 12);
    set_view(0, 0, 0, 32'sh80000000);
    test_random(150, 12, 12);
    set_view(0, 0, 32'sh00010000, 0);
    test_random(550, 12, 12);

    wait (expected_lines.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
